/* rtl/core/ust_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique set table package
// Sizes, operation and status codes shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package ust_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 6;
    localparam int COUNT_W    = 7;

    typedef logic [1:0]                t_mode;
    typedef logic [1:0]                t_status;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [POSITION_W-1:0]     t_position;
    typedef logic [COUNT_W-1:0]        t_entry_count;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [CNT_W-1:0]          t_cnt;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_FIND   = 2'd1;
    localparam t_mode MODE_DELETE = 2'd2;

    localparam t_status STATUS_DONE    = 2'd0;
    localparam t_status STATUS_PRESENT = 2'd1;
    localparam t_status STATUS_ABSENT  = 2'd2;
    localparam t_status STATUS_FULL    = 2'd3;

endpackage

/* rtl/core/ust_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique set table channels
// Request channel (operation and value) and response channel (lookup result).
// ----------------------------------------------------------------------------
interface ust_req_if;
    logic               valid;
    logic               ready;
    ust_pkg::t_mode     mode;
    ust_pkg::t_value    value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ust_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  found;
    ust_pkg::t_position    position;
    ust_pkg::t_entry_count entry_count;
    ust_pkg::t_status      status;

    modport source (output valid, output found, output position, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input found, input position, input entry_count,
                    input status, output ready);
endinterface

/* rtl/core/unique_set_table.sv */
`timescale 1ns / 1ps
// Walk: search and shift-down together walk at most count words (one read
//   per cycle; search compares each word, shift-down writes it back).
// Requests: one at a time, a new one taken only in idle; a held response
//   stalls the next request.
// Reset: synchronous, active low; clears count and control, not table words.
// ----------------------------------------------------------------------------
// Unique set table
// Set of distinct 32-bit values kept packed in a table with an entry count:
// insert if absent, find, and delete with shift-down of later entries.
// ----------------------------------------------------------------------------
module unique_set_table (
    input  logic i_clk,
    input  logic i_rst_n,
    ust_req_if.sink   i_req,
    ust_rsp_if.source o_rsp
);
    import ust_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    // Table storage: one write port, one registered read port
    t_value mem [CAPACITY];

    logic       [2:0] r_state, n_state;
    t_mode            r_mode, n_mode;
    t_value           r_value, n_value;
    t_cnt             r_count, n_count;
    t_cnt             r_k, n_k;         // walk pointer (next address to read)
    logic             r_pend, n_pend;   // a read is in flight
    t_idx             r_pidx, n_pidx;   // address of the word in flight
    logic             r_hit, n_hit;
    t_idx             r_hidx, n_hidx;
    t_status          r_status, n_status;
    t_value           r_rd_data;

    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    t_position        r_out_pos, n_out_pos;
    t_entry_count     r_out_cnt, n_out_cnt;
    t_status          r_out_status, n_out_status;

    logic             rd_en;
    t_idx             rd_addr;
    logic             wr_en;
    t_idx             wr_addr;
    t_value           wr_data;
    logic             cmp_eq;
    logic [31:0]      pos_wide;
    logic [31:0]      cnt_wide;

    // Compare unit: word in flight against the request value
    assign cmp_eq = r_pend && (r_rd_data == r_value);

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_rsp.status      = r_out_status;

    // Fold index and count into the fixed output field widths
    assign pos_wide = r_hit ? 32'(r_hidx) : 32'd0;
    assign cnt_wide = 32'(r_count);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_value      = r_value;
        n_count      = r_count;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_hit        = r_hit;
        n_hidx       = r_hidx;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_k[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_pidx;
        wr_data      = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_value = i_req.value;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                    n_hidx  = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Compare the word in flight, issue the next read unless it hit
                if (cmp_eq) begin
                    n_hit   = 1'b1;
                    n_hidx  = r_pidx;
                    n_pend  = 1'b0;
                    n_state = S_ACT;
                end else if (r_k < r_count) begin
                    rd_en  = 1'b1;
                    n_pidx = r_k[IDX_W-1:0];
                    n_pend = 1'b1;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_RESP;
                priority if (r_mode == MODE_INSERT) begin
                    if (r_hit) begin
                        n_status = STATUS_PRESENT;
                    end else if (r_count >= CNT_W'(CAPACITY)) begin
                        n_status = STATUS_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = r_count[IDX_W-1:0];
                        wr_data  = r_value;
                        n_count  = r_count + 1'b1;
                        n_status = STATUS_DONE;
                    end
                end else if (r_mode == MODE_DELETE) begin
                    if (r_hit) begin
                        // Walk the later entries down one place
                        n_k     = CNT_W'(r_hidx) + 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_status = STATUS_ABSENT;
                    end
                end else begin
                    n_status = r_hit ? STATUS_DONE : STATUS_ABSENT;
                end
            end
            S_SHIFT: begin
                // Write back the word read last cycle one place lower
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx;
                    wr_data = r_rd_data;
                end
                if (r_k < r_count) begin
                    rd_en  = 1'b1;
                    n_pidx = IDX_W'(r_k - 1'b1);
                    n_pend = 1'b1;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - 1'b1;
                    n_status = STATUS_DONE;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                // Hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_hit;
                    n_out_pos    = pos_wide[POSITION_W-1:0];
                    n_out_cnt    = cnt_wide[COUNT_W-1:0];
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table: write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_k          <= n_k;
        r_pidx       <= n_pidx;
        r_hit        <= n_hit;
        r_hidx       <= n_hidx;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
        r_out_status <= n_out_status;
    end

endmodule

/* bench/unique_set_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique set table testbench
// Drives insert, find and delete requests into the set table and checks each
// response against a scoreboard. The scoreboard keeps its own packed copy of
// the set. A short table of directed requests covers the empty table, extreme
// values, duplicates, unknown operation codes and deletes at the head, middle
// and tail. Random rounds follow, in turn: fill the table to capacity and
// beyond, mixed traffic, and drain it. Both sides idle at random, and once the
// response side stalls long enough to back up the request side.
// ----------------------------------------------------------------------------
module unique_set_table_test;
    import ust_pkg::*;

    localparam int    ITEMS      = 1250;          // stop starting rounds past this
    localparam int    MAX_GAP    = 15;            // longest idle per transfer
    localparam int    DRAIN_WAIT = 2 * CAPACITY + 8;
    localparam int    HOLD_AFTER = 300;           // requests before the long stall
    localparam int    HOLD_LEN   = 400;           // cycles of the long stall
    localparam t_mode MODE_SPARE = 2'd3;          // unused code, behaves as find

    localparam t_value V_MIN  = 32'sh8000_0000;
    localparam t_value V_MAX  = 32'sh7FFF_FFFF;
    localparam t_value V_ODD  = 32'sh5555_5555;
    localparam t_value V_EVEN = 32'shAAAA_AAAA;

    // One response as the block reports it.
    typedef struct packed {
        logic         found;
        t_position    position;
        t_entry_count entry_count;
        t_status      status;
    } t_lookup;

    // One directed request; want is used only when typed is set.
    typedef struct packed {
        t_mode   mode;
        t_value  value;
        logic    typed;
        t_lookup want;
    } t_probe;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ust_req_if req_if ();
    ust_rsp_if rsp_if ();

    unique_set_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_value  set_q[$];       // scoreboard copy of the table, index is position
    t_lookup lookup_q[$];    // expected responses, oldest first
    t_probe  probe_tbl[$];   // directed requests
    int      req_cnt  = 0;   // requests transferred so far
    int      err_cnt  = 0;
    int      rsp_wait = 0;   // cycles left with ready low on the response side
    logic    no_idle  = 1'b0;
    logic    long_hold;

    always #1 i_clk = ~i_clk;

    // Draw an idle count for one transfer; none during gap-free rounds.
    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(MAX_GAP));
    endfunction

    // Apply one request to the scoreboard set and return the response it
    // should produce. Only entries below the count are searched.
    function automatic t_lookup set_update(input t_mode m, input t_value v);
        t_lookup r;
        int      at;
        at = -1;
        foreach (set_q[k])
            if (at < 0 && set_q[k] == v)
                at = k;
        r = '0;
        if (at >= 0) begin
            r.found    = 1'b1;
            r.position = t_position'(at);
        end
        unique case (m)
            MODE_INSERT: begin
                if (at >= 0) begin
                    r.status = STATUS_PRESENT;
                end else if (set_q.size() >= CAPACITY) begin
                    r.status = STATUS_FULL;      // refuse, table unchanged
                end else begin
                    set_q.push_back(v);
                    r.status = STATUS_DONE;
                end
            end
            MODE_DELETE: begin
                if (at >= 0) begin
                    set_q.delete(at);            // later entries move down one
                    r.status = STATUS_DONE;
                end else begin
                    r.status = STATUS_ABSENT;
                end
            end
            default: r.status = (at >= 0) ? STATUS_DONE : STATUS_ABSENT;
        endcase
        r.entry_count = t_entry_count'(set_q.size());
        return r;
    endfunction

    // Pick a request value: a stored one with the given odds, else a value
    // near zero (so misses repeat and collide) or any 32-bit pattern.
    function automatic t_value pick_value(input int hit_pct);
        if (set_q.size() != 0 && int'($urandom_range(99)) < hit_pct)
            return set_q[$urandom_range(set_q.size() - 1)];
        if ($urandom_range(3) == 0)
            return t_value'($urandom_range(15)) - t_value'(8);
        return t_value'($urandom());
    endfunction

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offer one request after a random idle and hold it until the transfer.
    // Valid is only lowered before a nonzero idle, so back-to-back requests
    // keep it high without a second assignment in the same step.
    task automatic issue_request(input t_mode m, input t_value v,
                                 input logic typed, input t_lookup want);
        t_lookup model;
        int      gap;
        gap = draw_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= m;
        req_if.value <= v;
        do @(posedge i_clk); while (!req_if.ready);
        // Advance the scoreboard at the transfer; typed rows override its answer.
        model = set_update(m, v);
        lookup_q.push_back(typed ? want : model);
        req_cnt++;
    endtask

    // Response side: check each transfer against the oldest expectation, then
    // draw a stall for the next one. The long hold forces ready low on top.
    always @(posedge i_clk) begin : response_side
        t_lookup want;
        if (!i_rst_n) begin
            rsp_wait = 0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = lookup_q.pop_front();
                    if (rsp_if.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b",
                                                  rsp_if.found, want.found));
                    if (rsp_if.position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  rsp_if.position, want.position));
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  rsp_if.entry_count, want.entry_count));
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp_if.status, want.status));
                end
                rsp_wait = draw_gap();
            end else if (rsp_wait != 0) begin
                rsp_wait--;
            end
            rsp_if.ready <= !long_hold && (rsp_wait == 0);
        end
    end

    // Long stall: hold the response side off while requests keep coming, so
    // the block fills up and holds its request ready low.
    initial begin
        long_hold = 1'b0;
        wait (req_cnt >= HOLD_AFTER);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Stimulus and end of run.
    initial begin : stimulus
        t_mode m;
        int    round;
        int    pick;

        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_FIND;
        req_if.value <= '0;
        round = 0;

        // Directed part. Typed rows hold answers that follow from the empty
        // table and the values inserted so far; the rest use the scoreboard.
        // Probe the empty table with every operation.
        probe_tbl.push_back('{MODE_FIND,   t_value'(0), 1'b1, '{1'b0, 6'd0, 7'd0, STATUS_ABSENT}});
        probe_tbl.push_back('{MODE_DELETE, t_value'(0), 1'b1, '{1'b0, 6'd0, 7'd0, STATUS_ABSENT}});
        probe_tbl.push_back('{MODE_SPARE,  t_value'(0), 1'b1, '{1'b0, 6'd0, 7'd0, STATUS_ABSENT}});
        // Extremes, then a duplicate insert.
        probe_tbl.push_back('{MODE_INSERT, V_MIN, 1'b1, '{1'b0, 6'd0, 7'd1, STATUS_DONE}});
        probe_tbl.push_back('{MODE_INSERT, V_MAX, 1'b1, '{1'b0, 6'd0, 7'd2, STATUS_DONE}});
        probe_tbl.push_back('{MODE_INSERT, V_MIN, 1'b1, '{1'b1, 6'd0, 7'd2, STATUS_PRESENT}});
        probe_tbl.push_back('{MODE_FIND,   V_MAX, 1'b1, '{1'b1, 6'd1, 7'd2, STATUS_DONE}});
        probe_tbl.push_back('{MODE_SPARE,  V_MAX, 1'b1, '{1'b1, 6'd1, 7'd2, STATUS_DONE}});
        probe_tbl.push_back('{MODE_INSERT, t_value'(0), 1'b1, '{1'b0, 6'd0, 7'd3, STATUS_DONE}});
        // Alternating bit patterns and neighbors of zero.
        probe_tbl.push_back('{MODE_INSERT, t_value'(-1), 1'b0, '0});
        probe_tbl.push_back('{MODE_INSERT, t_value'(1),  1'b0, '0});
        probe_tbl.push_back('{MODE_INSERT, V_ODD,        1'b0, '0});
        probe_tbl.push_back('{MODE_INSERT, V_EVEN,       1'b0, '0});
        probe_tbl.push_back('{MODE_FIND,   t_value'(-1), 1'b0, '0});
        // Delete at the head, then check the shift.
        probe_tbl.push_back('{MODE_DELETE, V_MIN, 1'b0, '0});
        probe_tbl.push_back('{MODE_FIND,   V_MAX, 1'b0, '0});
        // Delete at the tail, twice; the second misses.
        probe_tbl.push_back('{MODE_DELETE, V_EVEN, 1'b0, '0});
        probe_tbl.push_back('{MODE_DELETE, V_EVEN, 1'b0, '0});
        probe_tbl.push_back('{MODE_FIND,   t_value'(1), 1'b0, '0});
        // Reinsert a deleted value, then delete from the middle.
        probe_tbl.push_back('{MODE_INSERT, V_MIN,       1'b0, '0});
        probe_tbl.push_back('{MODE_DELETE, t_value'(1), 1'b0, '0});
        probe_tbl.push_back('{MODE_FIND,   V_MIN,       1'b0, '0});
        probe_tbl.push_back('{MODE_SPARE,  V_ODD,       1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_tbl[k])
            issue_request(probe_tbl[k].mode, probe_tbl[k].value,
                          probe_tbl[k].typed, probe_tbl[k].want);

        // Random rounds: fill, mixed, drain. Every fourth round runs gap-free.
        while (req_cnt < ITEMS) begin
            no_idle = (round % 4 == 3);
            case (round % 3)
                0: begin
                    // Fill to capacity with mostly new values, then push on
                    // a few more so full-table refusals and duplicates show.
                    while (set_q.size() < CAPACITY) begin
                        if ($urandom_range(4) == 0)
                            issue_request(MODE_FIND, pick_value(50), 1'b0, '0);
                        else
                            issue_request(MODE_INSERT, pick_value(10), 1'b0, '0);
                    end
                    repeat (4) issue_request(MODE_INSERT, pick_value(30), 1'b0, '0);
                end
                1: begin
                    repeat (150) begin
                        pick = $urandom_range(9);
                        if (pick < 4)
                            m = MODE_INSERT;
                        else if (pick < 7)
                            m = MODE_FIND;
                        else if (pick < 9)
                            m = MODE_DELETE;
                        else
                            m = MODE_SPARE;
                        issue_request(m, pick_value(50), 1'b0, '0);
                    end
                end
                default: begin
                    // Drain with mostly hitting deletes, some misses and lookups.
                    while (set_q.size() != 0) begin
                        pick = $urandom_range(5);
                        if (pick == 0)
                            issue_request(MODE_FIND, pick_value(60), 1'b0, '0);
                        else if (pick == 1)
                            issue_request(MODE_SPARE, pick_value(60), 1'b0, '0);
                        else
                            issue_request(MODE_DELETE, pick_value(85), 1'b0, '0);
                    end
                end
            endcase
            round++;
        end
        req_if.valid <= 1'b0;
        no_idle = 1'b0;

        // Wait out every response, then a quiet stretch to catch strays.
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run, long stall included.
    initial begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", lookup_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ust_pkg.sv
rtl/core/ust_if.sv
rtl/core/unique_set_table.sv
bench/unique_set_table_test.sv
